### rtl/two_level_cache_controller_macros.svh
// Assertion macros shared by the cache controller RTL.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef TWO_LEVEL_CACHE_CONTROLLER_MACROS_SVH
`define TWO_LEVEL_CACHE_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLC_ASSERT_NOW(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLC_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### rtl/tlc_pkg.sv
// Shared types, constants and helper functions of the two-level cache controller.
// No dependencies; the front end, back end and top level import this package.
package tlc_pkg;

	localparam int ADDR_BITS   = 32;
	localparam int L1_SETS_MAX = 256;
	localparam int L1_WAYS_MAX = 8;
	localparam int L2_SETS_MAX = 1024;
	localparam int L2_WAYS_MAX = 16;

	localparam int L1_SET_W  = $clog2(L1_SETS_MAX);
	localparam int L2_SET_W  = $clog2(L2_SETS_MAX);
	localparam int L1_WAY_W  = $clog2(L1_WAYS_MAX);
	localparam int L2_WAY_W  = $clog2(L2_WAYS_MAX);
	localparam int L1_RANK_W = 3;
	localparam int L2_RANK_W = 4;

	localparam logic [L2_RANK_W-1:0] L1_RANK_MAX = 4'd7;
	localparam logic [L2_RANK_W-1:0] L2_RANK_MAX = 4'd15;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;

	typedef enum logic [2:0] {
		CFG_OFFSET_BITS = 3'd0,
		CFG_L1_SET_BITS = 3'd1,
		CFG_L1_WAYS     = 3'd2,
		CFG_L2_PRESENT  = 3'd3,
		CFG_L2_SET_BITS = 3'd4,
		CFG_L2_WAYS     = 3'd5,
		CFG_POLICY      = 3'd6,
		CFG_INCLUSIVE   = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_L1_EVAL,
		ST_L2_RD,
		ST_L2_EVAL,
		ST_INV_RD,
		ST_INV_EVAL,
		ST_FILL_RD,
		ST_FILL_EVAL,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic              action;
		logic [ADDR_BITS-1:0] address;
	} req_t;

	typedef struct packed {
		logic       l1_hit;
		logic       l1_writeback;
		logic       l2_read_done;
		logic       l2_read_miss;
		logic       l2_write_done;
		logic       l2_write_miss;
		logic [1:0] l2_writebacks;
		logic [1:0] direct_writebacks;
		logic [2:0] memory_transfers;
	} rsp_t;

	// Effective geometry after saturation of the configuration registers.
	typedef struct packed {
		logic [3:0] off;
		logic [3:0] l1_bits;
		logic [3:0] l1_ways;
		logic       l2_on;
		logic [3:0] l2_bits;
		logic [4:0] l2_ways;
		logic       fifo;
		logic       inclusive;
	} geom_t;

	// Classified access as it waits in the queue.
	typedef struct packed {
		logic                action;
		logic [ADDR_BITS-1:0] address;
		logic [L1_SET_W-1:0] l1_set;
		logic [31:0]         l1_tag;
	} job_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} back_stat_t;

	typedef logic [L2_WAYS_MAX-1:0]                way_mask_t;
	typedef logic [L2_WAY_W-1:0]                   way_idx_t;
	typedef logic [L2_WAYS_MAX-1:0][L2_RANK_W-1:0] rank_vec_t;

	typedef struct packed {
		logic [L1_WAYS_MAX-1:0][31:0]          tag;
		logic [L1_WAYS_MAX-1:0]                vld;
		logic [L1_WAYS_MAX-1:0]                dirty;
		logic [L1_WAYS_MAX-1:0][L1_RANK_W-1:0] rank;
	} l1_row_t;

	typedef struct packed {
		logic [L2_WAYS_MAX-1:0][31:0] tag;
		logic [L2_WAYS_MAX-1:0]       vld;
		logic [L2_WAYS_MAX-1:0]       dirty;
		rank_vec_t                    rank;
	} l2_row_t;

	function automatic logic [L2_SET_W-1:0] set_of(logic [ADDR_BITS-1:0] a,
			logic [3:0] off, logic [3:0] bits);
		logic [ADDR_BITS-1:0] sh;
		logic [ADDR_BITS-1:0] msk;
		sh  = a >> off;
		msk = ~({ADDR_BITS{1'b1}} << bits);
		return L2_SET_W'(sh & msk);
	endfunction

	function automatic logic [31:0] tag_of(logic [ADDR_BITS-1:0] a,
			logic [3:0] off, logic [3:0] bits);
		return 32'(a >> (5'(off) + 5'(bits)));
	endfunction

	function automatic logic [ADDR_BITS-1:0] block_addr(logic [31:0] tag,
			logic [L2_SET_W-1:0] s, logic [3:0] off, logic [3:0] bits);
		return (ADDR_BITS'(tag) << (5'(off) + 5'(bits))) | (ADDR_BITS'(s) << off);
	endfunction

	function automatic way_mask_t ways_mask(logic [4:0] n);
		way_mask_t m;
		for (int j = 0; j < L2_WAYS_MAX; j++) m[j] = (5'(j) < n);
		return m;
	endfunction

	function automatic way_idx_t first_set(way_mask_t m);
		way_idx_t ix;
		ix = '0;
		for (int j = L2_WAYS_MAX - 1; j >= 0; j--) if (m[j]) ix = way_idx_t'(j);
		return ix;
	endfunction

	// Tournament over the enabled ways; ties go to the lower way.
	function automatic way_idx_t pick_oldest(way_mask_t en, rank_vec_t r);
		way_mask_t                             e;
		rank_vec_t                             rr;
		logic [L2_WAYS_MAX-1:0][L2_WAY_W-1:0] ix;
		e  = en;
		rr = r;
		for (int j = 0; j < L2_WAYS_MAX; j++) ix[j] = way_idx_t'(j);
		for (int lvl = 0; lvl < L2_WAY_W; lvl++) begin
			for (int k = 0; k < (L2_WAYS_MAX >> (lvl + 1)); k++) begin
				if (e[2*k+1] && (!e[2*k] || rr[2*k+1] > rr[2*k])) begin
					e[k]  = 1'b1;
					rr[k] = rr[2*k+1];
					ix[k] = ix[2*k+1];
				end else begin
					e[k]  = e[2*k];
					rr[k] = rr[2*k];
					ix[k] = ix[2*k];
				end
			end
		end
		return ix[0];
	endfunction

	function automatic rank_vec_t rank_touch(way_mask_t live, rank_vec_t r, way_idx_t w,
			logic [L2_RANK_W-1:0] rmax);
		rank_vec_t o;
		o = r;
		for (int j = 0; j < L2_WAYS_MAX; j++)
			if (way_idx_t'(j) != w && live[j] && r[j] < r[w] && r[j] < rmax)
				o[j] = r[j] + 1'b1;
		o[w] = '0;
		return o;
	endfunction

	function automatic rank_vec_t rank_insert(way_mask_t live, rank_vec_t r, way_idx_t w,
			logic [L2_RANK_W-1:0] rmax);
		rank_vec_t o;
		o = r;
		for (int j = 0; j < L2_WAYS_MAX; j++)
			if (way_idx_t'(j) != w && live[j] && r[j] < rmax) o[j] = r[j] + 1'b1;
		o[w] = '0;
		return o;
	endfunction

	function automatic rank_vec_t rank_drop(way_mask_t live, rank_vec_t r, way_idx_t w);
		rank_vec_t o;
		o = r;
		for (int j = 0; j < L2_WAYS_MAX; j++)
			if (way_idx_t'(j) != w && live[j] && r[j] > r[w]) o[j] = r[j] - 1'b1;
		o[w] = '0;
		return o;
	endfunction

endpackage

### rtl/tlc_front.sv
// Front end: accepts accesses, splits the address for L1 and queues the job.
// Depends on tlc_pkg.
module tlc_front import tlc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  geom_t      geom,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	input  back_stat_t stat,
	output logic       job_valid,
	output job_t       job
);

	job_t                   fifo_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   cnt_q;
	logic                   push;
	logic                   pop;
	job_t                   job_in;

	assign req_ready = (cnt_q != (QUEUE_PTR_W+1)'(QUEUE_DEPTH)) && !stat.clearing;
	assign push      = req_valid && req_ready;
	assign job_valid = (cnt_q != '0);
	assign pop       = stat.take && job_valid;
	assign job       = fifo_q[rd_ptr_q];

	always_comb begin
		job_in.action  = req.action;
		job_in.address = req.address;
		job_in.l1_set  = L1_SET_W'(set_of(req.address, geom.off, geom.l1_bits));
		job_in.l1_tag  = tag_of(req.address, geom.off, geom.l1_bits);
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/tlc_back.sv
// Back end: sequencer over the L1 and L2 tag memories and the result register.
// Depends on tlc_pkg and two_level_cache_controller_macros.svh.
`include "two_level_cache_controller_macros.svh"
module tlc_back import tlc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  geom_t      geom,
	input  logic       job_valid,
	input  job_t       job,
	output back_stat_t stat,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp
);

	// memories
	l1_row_t             l1_mem [L1_SETS_MAX];
	l2_row_t             l2_mem [L2_SETS_MAX];
	logic [L1_SETS_MAX-1:0] l1_init_q;
	l1_row_t             l1_rdata_q;
	logic                l1_rinit_q;
	l2_row_t             l2_rdata_q;
	logic                l1_re, l1_we, l2_re, l2_we;
	logic [L1_SET_W-1:0] l1_raddr, l1_waddr;
	logic [L2_SET_W-1:0] l2_raddr, l2_waddr;
	l1_row_t             l1_wdata;
	l2_row_t             l2_wdata;

	back_state_t         state_q, state_d;
	logic [L2_SET_W-1:0] clr_cnt_q, clr_cnt_d;
	logic                out_valid_q, out_load;
	rsp_t                out_q, res;

	logic                act_q, act_d;
	logic [ADDR_BITS-1:0] addr_q, addr_d;
	logic [L1_SET_W-1:0] set_q, set_d;
	logic [31:0]         tag_q, tag_d;
	way_idx_t            way_q, way_d;
	logic                hit_q, hit_d, l1wb_q, l1wb_d, rd_q, rd_d, rmiss_q, rmiss_d;
	logic                wd_q, wd_d, wmiss_q, wmiss_d;
	logic [1:0]          l2wb_q, l2wb_d, direct_q, direct_d;
	logic [ADDR_BITS-1:0] op_addr_q, op_addr_d;
	logic                op_write_q, op_write_d, phase_q, phase_d;
	logic [L2_SET_W-1:0] l2set_q, l2set_d;
	logic [31:0]         op_tag_q, op_tag_d;
	logic [ADDR_BITS-1:0] ev_addr_q, ev_addr_d;
	logic                ev_dirty_q, ev_dirty_d;
	logic [L1_SET_W-1:0] inv_set_q, inv_set_d;
	logic [31:0]         inv_tag_q, inv_tag_d;
	logic                op_done;

	l1_row_t             r1;
	logic [31:0]         t1;
	way_mask_t           en1, v1, d1, h1, nv1, nd1;
	rank_vec_t           k1, nk1;
	way_idx_t            w1, vic1;
	way_mask_t           en2, h2, nv2, nd2;
	rank_vec_t           nk2;
	logic [L2_WAYS_MAX-1:0][31:0] nt2;
	way_idx_t            w2, vic2;

	function automatic l1_row_t l1_pack(l1_row_t base, way_mask_t v, way_mask_t d,
			rank_vec_t k);
		l1_row_t o;
		o = base;
		for (int j = 0; j < L1_WAYS_MAX; j++) begin
			o.vld[j]   = v[j];
			o.dirty[j] = d[j];
			o.rank[j]  = k[j][L1_RANK_W-1:0];
		end
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (l1_we) l1_mem[l1_waddr] <= l1_wdata;
		if (l1_re) l1_rdata_q <= l1_mem[l1_raddr];
		if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
		if (l2_re) l2_rdata_q <= l2_mem[l2_raddr];
	end

	// One init bit per L1 set; a set never written reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_init_q  <= '0;
			l1_rinit_q <= 1'b0;
		end else begin
			if (l1_we) l1_init_q[l1_waddr] <= 1'b1;
			if (l1_re) l1_rinit_q <= l1_init_q[l1_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_cnt_q <= clr_cnt_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		act_q      <= act_d;
		addr_q     <= addr_d;
		set_q      <= set_d;
		tag_q      <= tag_d;
		way_q      <= way_d;
		hit_q      <= hit_d;
		l1wb_q     <= l1wb_d;
		rd_q       <= rd_d;
		rmiss_q    <= rmiss_d;
		wd_q       <= wd_d;
		wmiss_q    <= wmiss_d;
		l2wb_q     <= l2wb_d;
		direct_q   <= direct_d;
		op_addr_q  <= op_addr_d;
		op_write_q <= op_write_d;
		phase_q    <= phase_d;
		l2set_q    <= l2set_d;
		op_tag_q   <= op_tag_d;
		ev_addr_q  <= ev_addr_d;
		ev_dirty_q <= ev_dirty_d;
		inv_set_q  <= inv_set_d;
		inv_tag_q  <= inv_tag_d;
		if (out_load) out_q <= res;
	end

	always_comb begin
		res.l1_hit            = hit_q;
		res.l1_writeback      = l1wb_q;
		res.l2_read_done      = rd_q;
		res.l2_read_miss      = rmiss_q;
		res.l2_write_done     = wd_q;
		res.l2_write_miss     = wmiss_q;
		res.l2_writebacks     = l2wb_q;
		res.direct_writebacks = direct_q;
		if (geom.l2_on)
			res.memory_transfers = 3'(rmiss_q) + 3'(wmiss_q) + 3'(l2wb_q) + 3'(direct_q);
		else
			res.memory_transfers = 3'(!hit_q) + 3'(l1wb_q);
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		// L1 row view: an unwritten set reads as empty
		r1 = l1_rdata_q;
		if (!l1_rinit_q) begin
			r1.vld   = '0;
			r1.dirty = '0;
			r1.rank  = '0;
		end
		t1  = (state_q == ST_INV_EVAL) ? inv_tag_q : tag_q;
		en1 = ways_mask({1'b0, geom.l1_ways});
		v1  = '0;
		d1  = '0;
		k1  = '0;
		h1  = '0;
		for (int j = 0; j < L1_WAYS_MAX; j++) begin
			v1[j] = r1.vld[j];
			d1[j] = r1.dirty[j];
			k1[j] = L2_RANK_W'(r1.rank[j]);
			h1[j] = en1[j] && r1.vld[j] && (r1.tag[j] == t1);
		end
		w1   = first_set(h1);
		vic1 = (|(en1 & ~v1)) ? first_set(en1 & ~v1) : pick_oldest(en1, k1);

		en2 = ways_mask(geom.l2_ways);
		for (int j = 0; j < L2_WAYS_MAX; j++)
			h2[j] = en2[j] && l2_rdata_q.vld[j] && (l2_rdata_q.tag[j] == op_tag_q);
		w2   = first_set(h2);
		vic2 = (|(en2 & ~l2_rdata_q.vld)) ? first_set(en2 & ~l2_rdata_q.vld)
		                                  : pick_oldest(en2, l2_rdata_q.rank);

		state_d    = state_q;
		clr_cnt_d  = clr_cnt_q;
		out_load   = 1'b0;
		act_d      = act_q;
		addr_d     = addr_q;
		set_d      = set_q;
		tag_d      = tag_q;
		way_d      = way_q;
		hit_d      = hit_q;
		l1wb_d     = l1wb_q;
		rd_d       = rd_q;
		rmiss_d    = rmiss_q;
		wd_d       = wd_q;
		wmiss_d    = wmiss_q;
		l2wb_d     = l2wb_q;
		direct_d   = direct_q;
		op_addr_d  = op_addr_q;
		op_write_d = op_write_q;
		phase_d    = phase_q;
		l2set_d    = l2set_q;
		op_tag_d   = op_tag_q;
		ev_addr_d  = ev_addr_q;
		ev_dirty_d = ev_dirty_q;
		inv_set_d  = inv_set_q;
		inv_tag_d  = inv_tag_q;
		op_done    = 1'b0;
		l1_re      = 1'b0;
		l1_we      = 1'b0;
		l2_re      = 1'b0;
		l2_we      = 1'b0;
		l1_raddr   = set_q;
		l1_waddr   = set_q;
		l2_raddr   = l2set_q;
		l2_waddr   = l2set_q;
		l1_wdata   = r1;
		l2_wdata   = l2_rdata_q;
		nv1        = v1;
		nd1        = d1;
		nk1        = k1;
		nv2        = l2_rdata_q.vld;
		nd2        = l2_rdata_q.dirty;
		nk2        = l2_rdata_q.rank;
		nt2        = l2_rdata_q.tag;
		stat.take     = 1'b0;
		stat.clearing = (state_q == ST_CLEAR);

		case (state_q)
			ST_CLEAR: begin
				// sweep L2 empty after reset, one set a cycle
				l2_we     = 1'b1;
				l2_waddr  = clr_cnt_q;
				l2_wdata  = '0;
				clr_cnt_d = clr_cnt_q + 1'b1;
				if (clr_cnt_q == L2_SET_W'(L2_SETS_MAX - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (job_valid) begin
					stat.take = 1'b1;
					act_d     = job.action;
					addr_d    = job.address;
					set_d     = job.l1_set;
					tag_d     = job.l1_tag;
					hit_d     = 1'b0;
					l1wb_d    = 1'b0;
					rd_d      = 1'b0;
					rmiss_d   = 1'b0;
					wd_d      = 1'b0;
					wmiss_d   = 1'b0;
					l2wb_d    = '0;
					direct_d  = '0;
					l1_re     = 1'b1;
					l1_raddr  = job.l1_set;
					state_d   = ST_L1_EVAL;
				end
			end
			ST_L1_EVAL: begin
				l1_we = 1'b1;
				if (|h1) begin
					hit_d = 1'b1;
					if (!geom.fifo) nk1 = rank_touch(en1 & v1, k1, w1, L1_RANK_MAX);
					if (act_q) nd1[w1] = 1'b1;
					state_d = ST_DONE;
				end else begin
					way_d = vic1;
					if (v1[vic1]) begin
						nk1       = rank_drop(en1 & v1, k1, vic1);
						nv1[vic1] = 1'b0;
					end
					if (v1[vic1] && d1[vic1]) begin
						l1wb_d = 1'b1;
					end
					if (v1[vic1] && d1[vic1] && geom.l2_on) begin
						wd_d       = 1'b1;
						op_addr_d  = block_addr(r1.tag[vic1[L1_WAY_W-1:0]],
						                        L2_SET_W'(set_q), geom.off, geom.l1_bits);
						op_write_d = 1'b1;
						phase_d    = 1'b0;
						state_d    = ST_L2_RD;
					end else if (geom.l2_on) begin
						rd_d       = 1'b1;
						op_addr_d  = addr_q;
						op_write_d = 1'b0;
						phase_d    = 1'b1;
						state_d    = ST_L2_RD;
					end else begin
						state_d = ST_FILL_RD;
					end
				end
				l1_wdata = l1_pack(r1, nv1, nd1, nk1);
			end
			ST_L2_RD: begin
				l2_re    = 1'b1;
				l2_raddr = set_of(op_addr_q, geom.off, geom.l2_bits);
				l2set_d  = l2_raddr;
				op_tag_d = tag_of(op_addr_q, geom.off, geom.l2_bits);
				state_d  = ST_L2_EVAL;
			end
			ST_L2_EVAL: begin
				l2_we = 1'b1;
				if (|h2) begin
					if (!geom.fifo)
						nk2 = rank_touch(en2 & l2_rdata_q.vld, l2_rdata_q.rank, w2, L2_RANK_MAX);
					if (op_write_q) nd2[w2] = 1'b1;
					op_done = 1'b1;
				end else begin
					if (l2_rdata_q.vld[vic2]) begin
						ev_addr_d  = block_addr(l2_rdata_q.tag[vic2], l2set_q, geom.off,
						                        geom.l2_bits);
						ev_dirty_d = l2_rdata_q.dirty[vic2];
						nk2        = rank_drop(en2 & l2_rdata_q.vld, l2_rdata_q.rank, vic2);
						nv2[vic2]  = 1'b0;
					end
					nk2       = rank_insert(en2 & nv2, nk2, vic2, L2_RANK_MAX);
					nv2[vic2] = 1'b1;
					nt2[vic2] = op_tag_q;
					nd2[vic2] = op_write_q;
					if (phase_q) rmiss_d = 1'b1;
					else wmiss_d = 1'b1;
					if (l2_rdata_q.vld[vic2] && geom.inclusive) begin
						state_d = ST_INV_RD;
					end else begin
						if (l2_rdata_q.vld[vic2] && l2_rdata_q.dirty[vic2])
							l2wb_d = l2wb_q + 1'b1;
						op_done = 1'b1;
					end
				end
				l2_wdata.tag   = nt2;
				l2_wdata.vld   = nv2;
				l2_wdata.dirty = nd2;
				l2_wdata.rank  = nk2;
			end
			ST_INV_RD: begin
				l1_re     = 1'b1;
				l1_raddr  = L1_SET_W'(set_of(ev_addr_q, geom.off, geom.l1_bits));
				inv_set_d = l1_raddr;
				inv_tag_d = tag_of(ev_addr_q, geom.off, geom.l1_bits);
				state_d   = ST_INV_EVAL;
			end
			ST_INV_EVAL: begin
				// back-invalidate; a dirty L1 copy goes straight to memory
				l1_we    = 1'b1;
				l1_waddr = inv_set_q;
				if (|h1) begin
					nk1     = rank_drop(en1 & v1, k1, w1);
					nv1[w1] = 1'b0;
					if (d1[w1]) begin
						nd1[w1]  = 1'b0;
						direct_d = direct_q + 1'b1;
					end else if (ev_dirty_q) begin
						l2wb_d = l2wb_q + 1'b1;
					end
				end else if (ev_dirty_q) begin
					l2wb_d = l2wb_q + 1'b1;
				end
				l1_wdata = l1_pack(r1, nv1, nd1, nk1);
				op_done  = 1'b1;
			end
			ST_FILL_RD: begin
				l1_re   = 1'b1;
				state_d = ST_FILL_EVAL;
			end
			ST_FILL_EVAL: begin
				l1_we      = 1'b1;
				nk1        = rank_insert(en1 & v1, k1, way_q, L1_RANK_MAX);
				nv1[way_q] = 1'b1;
				nd1[way_q] = act_q;
				l1_wdata   = l1_pack(r1, nv1, nd1, nk1);
				l1_wdata.tag[way_q[L1_WAY_W-1:0]] = tag_q;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// after an L2 operation: victim write goes first, then the fill read
		if (op_done) begin
			if (!phase_q) begin
				rd_d       = 1'b1;
				op_addr_d  = addr_q;
				op_write_d = 1'b0;
				phase_d    = 1'b1;
				state_d    = ST_L2_RD;
			end else begin
				state_d = ST_FILL_RD;
			end
		end
	end

	`TLC_ASSERT_NOW(a_hit_quiet, rsp_valid && rsp.l1_hit, !rsp.l1_writeback && !rsp.l2_read_done && rsp.memory_transfers == 3'd0, "L1 hit reported back-side traffic")
	`TLC_ASSERT_NOW(a_write_needs_wb, rsp_valid && (rsp.l2_write_done || rsp.l2_read_miss), rsp.l2_read_done && (rsp.l1_writeback || !rsp.l2_write_done), "L2 flags inconsistent")
	`TLC_ASSERT_NOW(a_no_take_clear, stat.clearing, !stat.take, "job taken during L2 clear")
	`TLC_ASSERT_NEXT(a_take_starts, stat.take, state_q == ST_L1_EVAL, "taken job did not start L1 lookup")

endmodule

### rtl/two_level_cache_controller.sv
// Top level of the two-level write-back cache controller model.
// Depends on tlc_pkg, tlc_front and tlc_back.

// Each request is one read or write access; each yields exactly one response with the
// hit, writeback and memory-transfer counts of that access. The user must write the
// configuration registers through the cfg channel only while no request is in flight;
// the block does not enforce this. After reset the block clears every set of its L2 tag
// memory, one set a cycle, before it takes requests (configuration writes are taken at
// once). Accesses run one at a time in the back-end sequencer; each memory step reads a
// tag row and then writes it back: an L1 hit does one L1 step; an L1 miss adds one L2 step
// per L2 operation (victim write, fill read), one L1 step per inclusive back-invalidation
// and an L1 fill step. A two-entry queue in front accepts requests while the back end
// works, and a response register lets the next access start while a response waits.
module two_level_cache_controller import tlc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [4:0] cfg_data
);

	logic [3:0] off_bits_q, l1_set_bits_q, l1_ways_q, l2_set_bits_q;
	logic [4:0] l2_ways_q;
	logic       l2_present_q, policy_q, inclusive_q;
	geom_t      geom;
	logic       job_valid;
	job_t       job;
	back_stat_t stat;

	// Registers are always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_bits_q    <= 4'd5;
			l1_set_bits_q <= 4'd6;
			l1_ways_q     <= 4'd2;
			l2_present_q  <= 1'b1;
			l2_set_bits_q <= 4'd8;
			l2_ways_q     <= 5'd4;
			policy_q      <= 1'b0;
			inclusive_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OFFSET_BITS: off_bits_q    <= cfg_data[3:0];
				CFG_L1_SET_BITS: l1_set_bits_q <= cfg_data[3:0];
				CFG_L1_WAYS:     l1_ways_q     <= cfg_data[3:0];
				CFG_L2_PRESENT:  l2_present_q  <= cfg_data[0];
				CFG_L2_SET_BITS: l2_set_bits_q <= cfg_data[3:0];
				CFG_L2_WAYS:     l2_ways_q     <= cfg_data;
				CFG_POLICY:      policy_q      <= cfg_data[0];
				CFG_INCLUSIVE:   inclusive_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Saturate the geometry: offset and set bits to their maxima, ways to 1..max.
	always_comb begin
		geom.off     = (off_bits_q > 4'd8) ? 4'd8 : off_bits_q;
		geom.l1_bits = (l1_set_bits_q > 4'(L1_SET_W)) ? 4'(L1_SET_W) : l1_set_bits_q;
		geom.l2_bits = (l2_set_bits_q > 4'(L2_SET_W)) ? 4'(L2_SET_W) : l2_set_bits_q;
		if (l1_ways_q == '0) geom.l1_ways = 4'd1;
		else if (l1_ways_q > 4'(L1_WAYS_MAX)) geom.l1_ways = 4'(L1_WAYS_MAX);
		else geom.l1_ways = l1_ways_q;
		if (l2_ways_q == '0) geom.l2_ways = 5'd1;
		else if (l2_ways_q > 5'(L2_WAYS_MAX)) geom.l2_ways = 5'(L2_WAYS_MAX);
		else geom.l2_ways = l2_ways_q;
		geom.l2_on     = l2_present_q;
		geom.fifo      = policy_q;
		geom.inclusive = inclusive_q;
	end

	tlc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.stat      (stat),
		.job_valid (job_valid),
		.job       (job)
	);

	tlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.job_valid (job_valid),
		.job       (job),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

### tb/two_level_cache_controller_test.sv
// Self-checking testbench for the two-level write-back cache controller.
// Depends on tlc_pkg and the two_level_cache_controller RTL; predicts every response.
module two_level_cache_controller_test;
	import tlc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no request, response or register write accepted before giving up
	localparam int STALL_LIMIT = 6000;
	localparam int ITEMS_PER_PHASE = 175;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [4:0] cfg_data;

	two_level_cache_controller i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the cache state and the register file.
	int          geom_reg [8];
	bit          l1_vld [L1_SETS_MAX][L1_WAYS_MAX];
	bit          l1_dty [L1_SETS_MAX][L1_WAYS_MAX];
	int          l1_age [L1_SETS_MAX][L1_WAYS_MAX];
	logic [31:0] l1_tag [L1_SETS_MAX][L1_WAYS_MAX];
	bit          l2_vld [L2_SETS_MAX][L2_WAYS_MAX];
	bit          l2_dty [L2_SETS_MAX][L2_WAYS_MAX];
	int          l2_age [L2_SETS_MAX][L2_WAYS_MAX];
	logic [31:0] l2_tag [L2_SETS_MAX][L2_WAYS_MAX];
	int          n_l2_wb;
	int          n_direct_wb;

	rsp_t pending_rsp [$];
	int   failures;
	bit   quiet;

	// ---------------- geometry ----------------
	function automatic int offset_eff();
		return geom_reg[CFG_OFFSET_BITS] > 8 ? 8 : geom_reg[CFG_OFFSET_BITS];
	endfunction

	function automatic int fit_bits(int b, int hi, int max_sets);
		if (b > hi) b = hi;
		while (b > 0 && (1 << b) > max_sets) b--;
		return b;
	endfunction

	function automatic int set_bits(bit lvl2);
		return lvl2 ? fit_bits(geom_reg[CFG_L2_SET_BITS], 10, L2_SETS_MAX)
			: fit_bits(geom_reg[CFG_L1_SET_BITS], 8, L1_SETS_MAX);
	endfunction

	function automatic int way_count(bit lvl2);
		int w;
		int wmax;
		w    = lvl2 ? geom_reg[CFG_L2_WAYS] : geom_reg[CFG_L1_WAYS];
		wmax = lvl2 ? L2_WAYS_MAX : L1_WAYS_MAX;
		if (w == 0) return 1;
		return w > wmax ? wmax : w;
	endfunction

	function automatic int set_idx(logic [31:0] a, int b);
		return int'((a >> offset_eff()) & ((32'd1 << b) - 32'd1));
	endfunction

	function automatic logic [31:0] tag_bits(logic [31:0] a, int b);
		return a >> (offset_eff() + b);
	endfunction

	function automatic logic [31:0] line_addr(logic [31:0] t, int s, int b);
		return (t << (offset_eff() + b)) | (32'(s) << offset_eff());
	endfunction

	// ---------------- per-level accessors ----------------
	function automatic bit get_vld(bit h, int s, int j);
		return h ? l2_vld[s][j] : l1_vld[s][j];
	endfunction
	function automatic bit get_dty(bit h, int s, int j);
		return h ? l2_dty[s][j] : l1_dty[s][j];
	endfunction
	function automatic int get_age(bit h, int s, int j);
		return h ? l2_age[s][j] : l1_age[s][j];
	endfunction
	function automatic logic [31:0] get_tag(bit h, int s, int j);
		return h ? l2_tag[s][j] : l1_tag[s][j];
	endfunction
	function automatic void put_vld(bit h, int s, int j, bit v);
		if (h) l2_vld[s][j] = v; else l1_vld[s][j] = v;
	endfunction
	function automatic void put_dty(bit h, int s, int j, bit v);
		if (h) l2_dty[s][j] = v; else l1_dty[s][j] = v;
	endfunction
	function automatic void put_age(bit h, int s, int j, int v);
		if (h) l2_age[s][j] = v; else l1_age[s][j] = v;
	endfunction
	function automatic void put_tag(bit h, int s, int j, logic [31:0] v);
		if (h) l2_tag[s][j] = v; else l1_tag[s][j] = v;
	endfunction

	// ---------------- recency order ----------------
	function automatic void age_touch(bit h, int s, int w);
		int old;
		int rmax;
		old  = get_age(h, s, w);
		rmax = h ? 15 : 7;
		for (int j = 0; j < way_count(h); j++)
			if (j != w && get_vld(h, s, j) && get_age(h, s, j) < old && get_age(h, s, j) < rmax)
				put_age(h, s, j, get_age(h, s, j) + 1);
		put_age(h, s, w, 0);
	endfunction

	function automatic void age_insert(bit h, int s, int w);
		int rmax;
		rmax = h ? 15 : 7;
		for (int j = 0; j < way_count(h); j++)
			if (j != w && get_vld(h, s, j) && get_age(h, s, j) < rmax)
				put_age(h, s, j, get_age(h, s, j) + 1);
		put_age(h, s, w, 0);
		put_vld(h, s, w, 1'b1);
	endfunction

	function automatic void age_drop(bit h, int s, int w);
		int old;
		old = get_age(h, s, w);
		for (int j = 0; j < way_count(h); j++)
			if (j != w && get_vld(h, s, j) && get_age(h, s, j) > old)
				put_age(h, s, j, get_age(h, s, j) - 1);
		put_vld(h, s, w, 1'b0);
		put_age(h, s, w, 0);
	endfunction

	function automatic int victim_way(bit h, int s);
		int best;
		best = 0;
		for (int j = 0; j < way_count(h); j++)
			if (!get_vld(h, s, j)) return j;
		for (int j = 1; j < way_count(h); j++)
			if (get_age(h, s, j) > get_age(h, s, best)) best = j;
		return best;
	endfunction

	function automatic int hit_way(bit h, int s, logic [31:0] t);
		for (int j = 0; j < way_count(h); j++)
			if (get_vld(h, s, j) && get_tag(h, s, j) == t) return j;
		return -1;
	endfunction

	// ---------------- cache operations ----------------
	// Back-invalidate an L1 copy; a dirty copy goes straight to memory.
	function automatic bit l1_back_invalidate(logic [31:0] a);
		int b;
		int s;
		int w;
		b = set_bits(1'b0);
		s = set_idx(a, b);
		w = hit_way(1'b0, s, tag_bits(a, b));
		if (w < 0) return 1'b0;
		age_drop(1'b0, s, w);
		if (l1_dty[s][w]) begin
			l1_dty[s][w] = 1'b0;
			n_direct_wb++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void l2_alloc(logic [31:0] a, bit dirty);
		int          b;
		int          s;
		int          v;
		logic [31:0] va;
		bit          was_dirty;
		bit          direct;
		b = set_bits(1'b1);
		s = set_idx(a, b);
		v = victim_way(1'b1, s);
		if (l2_vld[s][v]) begin
			va        = line_addr(l2_tag[s][v], s, b);
			was_dirty = l2_dty[s][v];
			age_drop(1'b1, s, v);
			if (geom_reg[CFG_INCLUSIVE] != 0) begin
				direct = l1_back_invalidate(va);
				if (was_dirty && !direct) n_l2_wb++;
			end else if (was_dirty) begin
				n_l2_wb++;
			end
		end
		l2_tag[s][v] = tag_bits(a, b);
		l2_dty[s][v] = dirty;
		age_insert(1'b1, s, v);
	endfunction

	// Returns 1 on an L2 miss.
	function automatic bit l2_lookup(logic [31:0] a, bit is_write);
		int b;
		int s;
		int w;
		b = set_bits(1'b1);
		s = set_idx(a, b);
		w = hit_way(1'b1, s, tag_bits(a, b));
		if (w >= 0) begin
			if (geom_reg[CFG_POLICY] == 0) age_touch(1'b1, s, w);
			if (is_write) l2_dty[s][w] = 1'b1;
			return 1'b0;
		end
		l2_alloc(a, is_write);
		return 1'b1;
	endfunction

	function automatic rsp_t access_outcome(req_t r);
		rsp_t        o;
		int          b;
		int          s;
		int          w;
		int          v;
		int          mem;
		logic [31:0] va;
		bit          l2_on;
		o           = '0;
		n_l2_wb     = 0;
		n_direct_wb = 0;
		l2_on       = geom_reg[CFG_L2_PRESENT] != 0;
		b           = set_bits(1'b0);
		s           = set_idx(r.address, b);
		w           = hit_way(1'b0, s, tag_bits(r.address, b));
		if (w >= 0) begin
			o.l1_hit = 1'b1;
			if (geom_reg[CFG_POLICY] == 0) age_touch(1'b0, s, w);
			if (r.action) l1_dty[s][w] = 1'b1;
		end else begin
			v = victim_way(1'b0, s);
			if (l1_vld[s][v]) begin
				va = line_addr(l1_tag[s][v], s, b);
				age_drop(1'b0, s, v);
				if (l1_dty[s][v]) begin
					o.l1_writeback = 1'b1;
					if (l2_on) begin
						o.l2_write_done = 1'b1;
						o.l2_write_miss = l2_lookup(va, 1'b1);
					end
				end
			end
			if (l2_on) begin
				o.l2_read_done = 1'b1;
				o.l2_read_miss = l2_lookup(r.address, 1'b0);
			end
			l1_tag[s][v] = tag_bits(r.address, b);
			l1_dty[s][v] = r.action;
			age_insert(1'b0, s, v);
		end
		if (l2_on)
			mem = o.l2_read_miss + o.l2_write_miss + n_l2_wb + n_direct_wb;
		else
			mem = (o.l1_hit ? 0 : 1) + o.l1_writeback;
		o.l2_writebacks     = 2'(n_l2_wb);
		o.direct_writebacks = 2'(n_direct_wb);
		o.memory_transfers  = 3'(mem);
		return o;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	// ---------------- clock, reset, receiver ----------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stall the response side at random unless a quiet stretch is running.
	always @(posedge clk) begin
		if (!arst_n) rsp_ready <= 1'b0;
		else rsp_ready <= quiet || ($urandom_range(0, 99) >= 29);
	end

	// Predict each accepted request, mirror register writes, check each response.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_L2_PRESENT, CFG_POLICY, CFG_INCLUSIVE: geom_reg[cfg_index] = cfg_data & 1;
					CFG_L2_WAYS: geom_reg[cfg_index] = cfg_data;
					default: geom_reg[cfg_index] = cfg_data & 4'hF;
				endcase
			end
			if (req_valid && req_ready)
				pending_rsp.insert(pending_rsp.size(), access_outcome(req));
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					$error("response with no request outstanding");
					failures++;
				end else begin
					want = pending_rsp.pop_front();
					check_field("l1_hit", want.l1_hit, rsp.l1_hit);
					check_field("l1_writeback", want.l1_writeback, rsp.l1_writeback);
					check_field("l2_read_done", want.l2_read_done, rsp.l2_read_done);
					check_field("l2_read_miss", want.l2_read_miss, rsp.l2_read_miss);
					check_field("l2_write_done", want.l2_write_done, rsp.l2_write_done);
					check_field("l2_write_miss", want.l2_write_miss, rsp.l2_write_miss);
					check_field("l2_writebacks", want.l2_writebacks, rsp.l2_writebacks);
					check_field("direct_writebacks", want.direct_writebacks,
						rsp.direct_writebacks);
					check_field("memory_transfers", want.memory_transfers,
						rsp.memory_transfers);
				end
			end
		end
	end

	// Watchdog: count cycles in which no handshake completes.
	always @(posedge clk) begin
		int idle_cycles;
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ---------------- senders ----------------
	function automatic bit take_gap();
		return !quiet && ($urandom_range(0, 99) < 29);
	endfunction

	task automatic send_access(bit is_write, logic [31:0] addr);
		req_t r;
		r.action  = is_write;
		r.address = addr;
		if (take_gap()) begin
			req_valid <= 1'b0;
			do @(posedge clk); while (take_gap());
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		if (take_gap()) begin
			cfg_valid <= 1'b0;
			do @(posedge clk); while (take_gap());
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 5'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Drop both valids and hold until every predicted response has come back.
	task automatic drain();
		req_valid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic program_all(int v [8]);
		for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
		cfg_valid <= 1'b0;
	endtask

	// ---------------- tests ----------------
	// Tiny inclusive cache: hits, misses and back-invalidation; then L2 bypassed with dirty victims.
	task automatic test_directed();
		int tiny [8] = '{0, 0, 2, 1, 0, 1, 0, 1};
		int bypass [8] = '{8, 8, 1, 0, 0, 1, 1, 0};
		program_all(tiny);
		send_access(1'b1, 32'h0000_0000);  // cold miss
		send_access(1'b0, 32'h0000_0000);  // L1 hit
		send_access(1'b1, 32'hFFFF_FFFF);  // L2 evicts a line whose L1 copy is dirty
		send_access(1'b0, 32'h0000_0001);
		send_access(1'b1, 32'h0000_0002);
		send_access(1'b1, 32'h0000_0003);  // L2 evicts a line whose L1 copy is dirty
		send_access(1'b0, 32'h0000_0002);
		send_access(1'b0, 32'hFFFF_FFFF);
		send_access(1'b1, 32'h8000_0000);
		send_access(1'b0, 32'h7FFF_FFFF);
		drain();
		program_all(bypass);
		send_access(1'b1, 32'h0000_0000);  // L2 bypassed
		send_access(1'b1, 32'h0001_0000);  // dirty victim straight to memory
		send_access(1'b0, 32'h0001_0000);
		send_access(1'b0, 32'hFFFF_FFFF);
		send_access(1'b1, 32'hFFFF_FF00);
		drain();
	endtask

	// Random traffic over several geometries, extremes and out-of-range values among them.
	task automatic test_random();
		int          setting [8];
		logic [31:0] hot [16];
		logic [31:0] a;
		int          pick;
		int          phases [8][8] = '{
			'{5, 6, 2, 1, 8, 4, 0, 0},
			'{0, 0, 1, 1, 0, 1, 0, 1},
			'{8, 8, 8, 1, 10, 16, 1, 0},
			'{15, 15, 15, 1, 15, 31, 0, 1},
			'{2, 1, 3, 0, 2, 2, 1, 0},
			'{4, 2, 4, 1, 3, 2, 1, 1},
			'{3, 3, 0, 1, 1, 0, 0, 1},
			'{6, 2, 2, 1, 4, 8, 0, 1}
		};
		for (int p = 0; p < 8; p++) begin
			setting = phases[p];
			program_all(setting);
			// hot addresses, half of them aliasing one set with different tags
			for (int i = 0; i < 16; i++)
				hot[i] = (i < 8) ? $urandom() : (hot[0] ^ ($urandom() << 18));
			quiet = (p == 3);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					a = $urandom();
				else
					a = hot[$urandom_range(0, 15)] ^ $urandom_range(0, 255);
				send_access($urandom_range(0, 1), a);
			end
			quiet = 1'b0;
			drain();
		end
	endtask

	initial begin
		req_valid   = 1'b0;
		req         = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		failures    = 0;
		quiet       = 1'b0;
		geom_reg    = '{5, 6, 2, 1, 8, 4, 0, 0};
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		test_directed();
		test_random();
		repeat (40) @(posedge clk);
		if (failures == 0 && pending_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
